@@ rtl/core/modexp_pkg.sv @@
// Shared widths, constants and controller states for the modular exponentiation unit.
// No dependencies; used by modular_exponentiation_unit.
package modexp_pkg;

	// exponent bits scanned, most significant first
	localparam int EXP_BITS  = 32;
	// modulus width; products of two residues fit 2*MOD_BITS bits
	localparam int MOD_BITS  = 31;
	// fixed field widths of the stream interface
	localparam int BASE_W    = 32;
	localparam int EXP_W     = 32;
	localparam int RES_W     = 31;
	localparam int CFG_W     = 31;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 32;

	// multiplier shift register holds either the base or a residue
	localparam int MPLR_W = (BASE_W > MOD_BITS) ? BASE_W : MOD_BITS;
	// step counter over multiplier bits, bit counter over exponent bits
	localparam int STEP_W = (MPLR_W > 1) ? $clog2(MPLR_W) : 1;
	localparam int BIT_W  = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
	// extended width for the add/subtract candidates, with a sign bit
	localparam int EXT_W  = MOD_BITS + 3;

	localparam logic [CFG_W-1:0] MODULUS_RESET = CFG_W'(1000000007);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SQUARE,
		ST_MULT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		ADD_ONE,
		ADD_ACC,
		ADD_BASE
	} addend_sel_t;

endpackage

@@ rtl/core/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: base^exponent mod modulus by square-and-multiply.
// Throughput: one request at a time; a bit-serial modular multiplier retires one
// multiplier bit per cycle and is shared by base reduction, squaring and multiplying.
// Reset (arst_n, asynchronous): controller idle, output empty, modulus 1000000007.
module modular_exponentiation_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input stream
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [modexp_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // base [31:0], exponent [63:32]
	// result stream
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [modexp_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // power_result [30:0], zero [31]
	// modulus register write
	input  logic                                    cfg_we,
	input  logic [modexp_pkg::CFG_W-1:0]            cfg_wdata
);

	localparam int W = modexp_pkg::MOD_BITS;
	localparam int X = modexp_pkg::EXT_W;

	modexp_pkg::state_t               state_q, state_d;
	modexp_pkg::addend_sel_t          addend_sel;

	logic [W-1:0]                     mod_q;      // configured modulus
	logic [W-1:0]                     m_q;        // modulus in use for this request
	logic [W-1:0]                     b_q;        // base reduced modulo m_q
	logic [W-1:0]                     acc_q;      // running power
	logic [W-1:0]                     r_q;        // partial product of the serial multiplier
	logic [modexp_pkg::MPLR_W-1:0]    mplr_q;     // multiplier bits, MSB first
	logic [modexp_pkg::EXP_W-1:0]     exp_q;      // exponent bits, MSB first
	logic [modexp_pkg::STEP_W-1:0]    step_q;
	logic [modexp_pkg::BIT_W-1:0]     bit_q;
	logic                             out_valid_q;
	logic [W-1:0]                     out_data_q;

	logic [modexp_pkg::BASE_W-1:0]    in_base;
	logic [modexp_pkg::EXP_W-1:0]     in_exp;
	logic                             in_fire;
	logic                             mul_active;
	logic                             last_step;
	logic                             last_bit;
	logic                             out_load;
	logic [W-1:0]                     addend;
	logic [X-1:0]                     r2, a_x, m_x, t1, t2, t3, t4;
	logic [W-1:0]                     r_next;

	assign in_base = s_axis_tdata[modexp_pkg::BASE_W-1:0];
	assign in_exp  = s_axis_tdata[modexp_pkg::BASE_W +: modexp_pkg::EXP_W];
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// last multiplier bit: base reduction scans the base, the others scan a residue
	assign last_step = (state_q == modexp_pkg::ST_REDUCE)
		? (step_q == modexp_pkg::STEP_W'(modexp_pkg::BASE_W - 1))
		: (step_q == modexp_pkg::STEP_W'(W - 1));
	assign last_bit = (bit_q == modexp_pkg::BIT_W'(modexp_pkg::EXP_BITS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			modexp_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (in_exp[modexp_pkg::EXP_BITS-1:0] == '0)
						state_d = modexp_pkg::ST_FINISH;
					else
						state_d = modexp_pkg::ST_REDUCE;
				end
			end
			modexp_pkg::ST_REDUCE: begin
				if (last_step)
					state_d = modexp_pkg::ST_SQUARE;
			end
			modexp_pkg::ST_SQUARE: begin
				if (last_step) begin
					if (exp_q[modexp_pkg::EXP_W-1])
						state_d = modexp_pkg::ST_MULT;
					else if (last_bit)
						state_d = modexp_pkg::ST_FINISH;
				end
			end
			modexp_pkg::ST_MULT: begin
				if (last_step)
					state_d = last_bit ? modexp_pkg::ST_FINISH : modexp_pkg::ST_SQUARE;
			end
			modexp_pkg::ST_FINISH: begin
				if (!out_valid_q || m_axis_tready)
					state_d = modexp_pkg::ST_IDLE;
			end
			default: state_d = modexp_pkg::ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mul_active    = 1'b0;
		out_load      = 1'b0;
		addend_sel    = modexp_pkg::ADD_ONE;
		case (state_q)
			modexp_pkg::ST_IDLE:   s_axis_tready = 1'b1;
			modexp_pkg::ST_REDUCE: begin
				mul_active = 1'b1;
				addend_sel = modexp_pkg::ADD_ONE;
			end
			modexp_pkg::ST_SQUARE: begin
				mul_active = 1'b1;
				addend_sel = modexp_pkg::ADD_ACC;
			end
			modexp_pkg::ST_MULT: begin
				mul_active = 1'b1;
				addend_sel = modexp_pkg::ADD_BASE;
			end
			modexp_pkg::ST_FINISH: out_load = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_comb begin
		case (addend_sel)
			modexp_pkg::ADD_ONE:  addend = W'(1);
			modexp_pkg::ADD_ACC:  addend = acc_q;
			modexp_pkg::ADD_BASE: addend = b_q;
			default:              addend = W'(1);
		endcase
	end

	// one serial step: r = 2r (+ addend) mod m, all candidates formed in parallel
	always_comb begin
		r2 = X'(r_q) << 1;
		a_x = X'(addend);
		m_x = X'(m_q);
		t1 = r2 - m_x;
		t2 = r2 + a_x;
		t3 = t2 - m_x;
		t4 = t2 - (m_x << 1);
		if (mplr_q[modexp_pkg::MPLR_W-1]) begin
			if (!t4[X-1])
				r_next = t4[W-1:0];
			else if (!t3[X-1])
				r_next = t3[W-1:0];
			else
				r_next = t2[W-1:0];
		end else begin
			r_next = t1[X-1] ? r2[W-1:0] : t1[W-1:0];
		end
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mod_q <= modexp_pkg::MODULUS_RESET[W-1:0];
		else if (cfg_we)
			mod_q <= cfg_wdata[W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= modexp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (out_load)
			out_data_q <= acc_q;
		if (in_fire) begin
			// a zero modulus acts as a modulus of one
			m_q    <= (mod_q == '0) ? W'(1) : mod_q;
			exp_q  <= in_exp << (modexp_pkg::EXP_W - modexp_pkg::EXP_BITS);
			acc_q  <= W'(1);
			r_q    <= '0;
			step_q <= '0;
			bit_q  <= '0;
			mplr_q <= modexp_pkg::MPLR_W'(in_base) << (modexp_pkg::MPLR_W - modexp_pkg::BASE_W);
		end else if (mul_active) begin
			if (!last_step) begin
				// advance one multiplier bit
				r_q    <= r_next;
				mplr_q <= mplr_q << 1;
				step_q <= step_q + 1'b1;
			end else begin
				// product done: store it and restart the multiplier
				r_q    <= '0;
				step_q <= '0;
				case (state_q)
					modexp_pkg::ST_REDUCE: begin
						b_q    <= r_next;
						mplr_q <= modexp_pkg::MPLR_W'(acc_q) << (modexp_pkg::MPLR_W - W);
					end
					modexp_pkg::ST_SQUARE: begin
						acc_q  <= r_next;
						mplr_q <= modexp_pkg::MPLR_W'(r_next) << (modexp_pkg::MPLR_W - W);
						if (!exp_q[modexp_pkg::EXP_W-1]) begin
							exp_q <= exp_q << 1;
							bit_q <= bit_q + 1'b1;
						end
					end
					modexp_pkg::ST_MULT: begin
						acc_q  <= r_next;
						mplr_q <= modexp_pkg::MPLR_W'(r_next) << (modexp_pkg::MPLR_W - W);
						exp_q  <= exp_q << 1;
						bit_q  <= bit_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = modexp_pkg::OUT_DATA_W'(out_data_q);

endmodule

@@ bench/modular_exponentiation_unit_tb.sv @@
// Self-checking bench for modular_exponentiation_unit: random and directed base/exponent
// requests under several modulus settings, each result checked against a behavioral power.
// Depends on modexp_pkg and modular_exponentiation_unit.
module modular_exponentiation_unit_tb;

	localparam int HOLD_CYCLES  = 6000;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 2100;
	localparam int NUM_PHASES   = 10;
	// phase that starts with a long result back-pressure
	localparam int PRESSURE_PHASE = 2;

	// base in the low half, as on s_axis_tdata
	typedef struct packed {
		logic [modexp_pkg::EXP_W-1:0]  exponent;
		logic [modexp_pkg::BASE_W-1:0] base;
	} power_request_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_DENSE
	} rx_mode_t;

	// Expected powers in request order, with a private copy of the modulus
	class power_scoreboard;
		logic [modexp_pkg::CFG_W-1:0] modulus;
		logic [modexp_pkg::RES_W-1:0] expected_q[$];
		power_request_t               request_log[$];
		int                           fails;

		function new();
			modulus = modexp_pkg::MODULUS_RESET;
			fails = 0;
		endfunction

		// square-and-multiply, top exponent bit first
		function logic [modexp_pkg::RES_W-1:0] power_mod(logic [modexp_pkg::BASE_W-1:0] b,
			logic [modexp_pkg::EXP_W-1:0] e);
			logic [63:0] m;
			logic [63:0] bm;
			logic [63:0] acc;
			m = (modulus == '0) ? 64'd1 : 64'(modulus);
			if (e == '0)
				return modexp_pkg::RES_W'(1);
			bm = 64'(b) % m;
			acc = 64'd1;
			for (int i = modexp_pkg::EXP_BITS - 1; i >= 0; i--) begin
				acc = (acc * acc) % m;
				if (e[i])
					acc = (acc * bm) % m;
			end
			return acc[modexp_pkg::RES_W-1:0];
		endfunction

		function void note_request(power_request_t req);
			expected_q.insert(expected_q.size(), power_mod(req.base, req.exponent));
			request_log.insert(request_log.size(), req);
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH: %s", what);
			fails++;
		endtask

		task check_result(logic [modexp_pkg::OUT_DATA_W-1:0] data);
			logic [modexp_pkg::RES_W-1:0] want;
			power_request_t               req;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result 0x%08h with no request waiting", data));
			end else begin
				want = expected_q.pop_front();
				req = request_log.pop_front();
				if (data[modexp_pkg::RES_W-1:0] != want)
					report_mismatch($sformatf("base 0x%08h exp 0x%08h mod %0d: got %0d, want %0d",
						req.base, req.exponent, modulus, data[modexp_pkg::RES_W-1:0], want));
				if (data[modexp_pkg::OUT_DATA_W-1:modexp_pkg::RES_W] != '0)
					report_mismatch($sformatf("pad bits set in result 0x%08h", data));
			end
		endtask
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              s_axis_tvalid;
	logic                              s_axis_tready;
	logic [modexp_pkg::IN_DATA_W-1:0]  s_axis_tdata;  // base [31:0], exponent [63:32]
	logic                              m_axis_tvalid;
	logic                              m_axis_tready;
	logic [modexp_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // power_result [30:0], zero [31]
	logic                              cfg_we;
	logic [modexp_pkg::CFG_W-1:0]      cfg_wdata;

	power_scoreboard              sb;
	power_request_t               request_q[$];
	logic [modexp_pkg::CFG_W-1:0] phase_moduli [NUM_PHASES];
	int               phase_items [NUM_PHASES] = '{8, 8, 40, 12, 12, 30, 30, 40, 40, 35};
	int               burst_left = 1;
	int               gap_left = 0;
	int               hold_requests = 0;
	int               hold_seen = 0;
	int               hold_left = 0;
	rx_mode_t         rx_mode = RX_OPEN;
	int               rx_mode_left = 0;

	modular_exponentiation_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send queued requests in bursts, with short and occasional long gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_request(s_axis_tdata);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (request_q.size() != 0) begin
					s_axis_tdata <= request_q.pop_front();
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 6);
						gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2500)
							: $urandom_range(0, 4);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check results; stall on a changing pattern, or hold off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(50, 4000);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					RX_OPEN:   m_axis_tready <= 1'b1;
					RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
					default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Abort when work is pending but nothing has moved for too long
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stalled = 0;
			else if (request_q.size() != 0 || s_axis_tvalid || sb.expected_q.size() != 0)
				stalled++;
			else
				stalled = 0;
		end
		$display("modular_exponentiation_unit_tb NOT OK");
		$finish;
	end

	task automatic push_request(logic [modexp_pkg::BASE_W-1:0] b,
		logic [modexp_pkg::EXP_W-1:0] e);
		power_request_t req;
		req.base = b;
		req.exponent = e;
		request_q.insert(request_q.size(), req);
	endtask

	// Mix full-range values with edges: zero, one, all ones, multiples of the modulus
	task automatic push_random_request(logic [modexp_pkg::CFG_W-1:0] m);
		logic [31:0] mm;
		logic [modexp_pkg::BASE_W-1:0] b;
		logic [modexp_pkg::EXP_W-1:0] e;
		mm = (m == '0) ? 32'd1 : 32'(m);
		case ($urandom_range(0, 9))
			6:       b = '0;
			7:       b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
			8:       b = 32'(mm * $urandom_range(1, 3)) - $urandom_range(0, 1);
			9:       b = $urandom_range(0, 15);
			default: b = $urandom;
		endcase
		case ($urandom_range(0, 9))
			5, 6:    e = $urandom_range(1, 64);
			7:       e = '0;
			8:       e = $urandom_range(0, 1) ? 32'hFFFF_FFFF : (32'd1 << $urandom_range(0, 31));
			9:       e = $urandom | 32'h8000_0000;
			default: e = $urandom;
		endcase
		push_request(b, e);
	endtask

	// Block until every request is sent and every result is back
	task automatic wait_idle();
		while (request_q.size() != 0 || s_axis_tvalid || sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_modulus(logic [modexp_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.modulus = value;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		phase_moduli = '{modexp_pkg::CFG_W'(1), modexp_pkg::CFG_W'(0),
			modexp_pkg::CFG_W'(32'h7FFF_FFFF), modexp_pkg::CFG_W'(2), modexp_pkg::CFG_W'(3),
			modexp_pkg::CFG_W'(65537), modexp_pkg::CFG_W'($urandom_range(4, 1000)),
			modexp_pkg::CFG_W'($urandom_range(2, 32'h7FFF_FFFF)),
			modexp_pkg::CFG_W'($urandom | 32'h4000_0000),
			modexp_pkg::MODULUS_RESET};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed edges under the reset modulus
		push_request(32'h0000_0000, 32'h0000_0000);
		push_request(32'hFFFF_FFFF, 32'h0000_0000);
		push_request(32'h0000_0000, 32'h0000_0001);
		push_request(32'h0000_0000, 32'hFFFF_FFFF);
		push_request(32'h0000_0001, 32'hFFFF_FFFF);
		push_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_request(32'hFFFF_FFFF, 32'h0000_0001);
		push_request(32'd2, 32'd1);
		push_request(32'd2, 32'd31);
		push_request(32'd2, 32'h8000_0000);
		push_request(32'd1000000007, 32'd5);
		push_request(32'd1000000008, 32'd3);
		push_request(32'd1000000006, 32'd2);
		push_request(32'd3, 32'd1000000006);
		push_request(32'd12345, 32'h5555_5555);
		push_request(32'hDEAD_BEEF, 32'hAAAA_AAAA);
		push_request(32'd7, 32'd2);
		wait_idle();

		// Random requests under each modulus, zero and one among them
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_modulus(phase_moduli[p]);
			if (p == PRESSURE_PHASE)
				hold_requests++;
			push_request($urandom, '0);
			for (int i = 1; i < phase_items[p]; i++)
				push_random_request(phase_moduli[p]);
			wait_idle();
		end

		// Catch any stray result
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
		if (sb.fails == 0)
			$display("modular_exponentiation_unit_tb OK");
		else
			$display("modular_exponentiation_unit_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/modexp_pkg.sv
rtl/core/modular_exponentiation_unit.sv
bench/modular_exponentiation_unit_tb.sv
